### src/sbm_pkg.sv
// signed booth multiplier package: operand width, stage types and the booth step
// used by the booth cell and the top level, depends on nothing

package sbm_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int FIELD_WIDTH   = 16;
    localparam int PRODUCT_WIDTH = 32;

    typedef logic signed [FIELD_WIDTH-1:0]     t_field;
    typedef logic signed [PRODUCT_WIDTH-1:0]   t_product;
    typedef logic signed [OPERAND_WIDTH-1:0]   t_op;
    typedef logic signed [OPERAND_WIDTH:0]     t_acc;
    typedef logic signed [2*OPERAND_WIDTH:0]   t_full;

    typedef enum logic [1:0] {
        PAIR_NONE = 2'b00,
        PAIR_ADD  = 2'b01,
        PAIR_SUB  = 2'b10,
        PAIR_RUN  = 2'b11
    } t_pair;

    typedef struct packed {
        t_acc                     acc;
        logic [OPERAND_WIDTH-1:0] q;
        logic                     qm1;
        t_op                      mcand;
    } t_stage;

    function automatic t_stage booth_step(input t_stage s);
        t_stage r;
        t_acc   m;
        t_acc   sum;
        t_pair  pair;
        m    = t_acc'(s.mcand);
        pair = t_pair'({s.q[0], s.qm1});
        unique case (pair)
            PAIR_SUB: sum = s.acc - m;
            PAIR_ADD: sum = s.acc + m;
            default:  sum = s.acc;
        endcase
        r.mcand = s.mcand;
        r.qm1   = s.q[0];
        r.q     = {sum[0], s.q[OPERAND_WIDTH-1:1]};
        r.acc   = {sum[OPERAND_WIDTH], sum[OPERAND_WIDTH:1]};
        return r;
    endfunction

endpackage

### src/sbm_cell.sv
// one booth step with its stage register and valid/ready hand-off
// depends on sbm_pkg

module sbm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sbm_pkg::t_stage i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output sbm_pkg::t_stage o_data
);

    logic            r_valid;
    sbm_pkg::t_stage r_data;
    sbm_pkg::t_stage n_data;

    assign o_ready = !r_valid || i_ready;
    assign n_data  = sbm_pkg::booth_step(i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/signed_booth_multiplier.sv
// signed booth multiplier top level: a chain of booth cells, one step per cell
// depends on sbm_pkg and sbm_cell
//
// input channel: i_valid / o_ready with i_multiplicand and i_multiplier,
// output channel: o_valid / i_ready with o_product, the signed product.
// the chain holds OPERAND_WIDTH cells, 16 here; each cell performs one
// booth step (add, subtract or keep, then arithmetic shift) and registers it.
// each operand pair passes through the register of every cell in turn before its product appears.
// throughput: one operand pair per cycle while the output is not stalled, set by the one-step-per-cell chain.
// the last cell doubles as the output register.
// when the receiver stalls, the result holds in the last cell and the items
// behind it advance until they close up against it; each cell takes a new
// item whenever it is empty or its own item moves on, so o_ready falls only
// when every cell is full and the output is stalled.
// reset clears all cell valid flags; the pipeline is then empty and ready.

module signed_booth_multiplier (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [15:0]      i_multiplicand,
    input  logic signed [15:0]      i_multiplier,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [31:0]      o_product
);

    localparam int NumCells = sbm_pkg::OPERAND_WIDTH;

    sbm_pkg::t_stage s_data [0:NumCells];
    logic [NumCells:0] s_valid;
    logic [NumCells:0] s_ready;
    sbm_pkg::t_op      s_mcand;
    sbm_pkg::t_op      s_mplier;

    assign s_mcand  = sbm_pkg::t_op'(sbm_pkg::t_field'(i_multiplicand));
    assign s_mplier = sbm_pkg::t_op'(sbm_pkg::t_field'(i_multiplier));

    assign s_data[0].acc   = '0;
    assign s_data[0].q     = s_mplier;
    assign s_data[0].qm1   = 1'b0;
    assign s_data[0].mcand = s_mcand;
    assign s_valid[0]      = i_valid;
    assign o_ready         = s_ready[0];

    for (genvar k = 0; k < NumCells; k++) begin : g_cell
        sbm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_ready[k]),
            .i_data  (s_data[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_ready[k+1]),
            .o_data  (s_data[k+1])
        );
    end

    assign s_ready[NumCells] = i_ready;
    assign o_valid           = s_valid[NumCells];
    assign o_product = sbm_pkg::t_product'(
        sbm_pkg::t_full'({s_data[NumCells].acc, s_data[NumCells].q}));

    // stall reaches the input only when every cell holds an item
    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&s_valid[NumCells:1]))
        else $error("input stalled with an empty cell");

    // a zero multiplicand gives a zero product
    a_zero_mcand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && s_data[NumCells].mcand == '0) |-> (o_product == '0))
        else $error("nonzero product from zero multiplicand");

    // the chain comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (s_valid[NumCells:1] == '0))
        else $error("cell valid after reset");

endmodule

### tb/testbench.sv
// testbench for signed_booth_multiplier: random and directed operand pairs, a product
// scoreboard with its own booth predictor, random stalls on both channels
// depends on sbm_pkg and the signed_booth_multiplier rtl

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 200;
    localparam int PRINT_LIMIT = 20;

    class product_scoreboard;
        sbm_pkg::t_product expected_products[$];
        int                mismatches;

        function new();
            mismatches = 0;
        endfunction

        // radix-2 booth recoding over a 17-bit accumulator and the multiplier register
        static function sbm_pkg::t_product booth_product(sbm_pkg::t_field mcand,
                                                         sbm_pkg::t_field mplier);
            logic signed [16:0] acc;
            logic signed [16:0] m;
            logic signed [16:0] sum;
            logic [15:0]        q;
            logic               qm1;
            sbm_pkg::t_pair     pair;
            acc = '0;
            m   = {mcand[15], mcand};
            q   = mplier;
            qm1 = 1'b0;
            for (int i = 0; i < sbm_pkg::OPERAND_WIDTH; i++) begin
                pair = sbm_pkg::t_pair'({q[0], qm1});
                case (pair)
                    sbm_pkg::PAIR_SUB: sum = acc - m;
                    sbm_pkg::PAIR_ADD: sum = acc + m;
                    default:           sum = acc;
                endcase
                qm1 = q[0];
                q   = {sum[0], q[15:1]};
                acc = {sum[16], sum[16:1]};
            end
            return {acc[15:0], q};
        endfunction

        function void note_operands(sbm_pkg::t_field mcand, sbm_pkg::t_field mplier);
            expected_products.push_back(booth_product(mcand, mplier));
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_product(sbm_pkg::t_product got);
            sbm_pkg::t_product want;
            if (expected_products.size() == 0) begin
                report_mismatch($sformatf("product %0d with none expected", got));
            end else begin
                want = expected_products.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("product %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_ready;
    sbm_pkg::t_field   i_multiplicand = '0;
    sbm_pkg::t_field   i_multiplier   = '0;
    logic              o_valid;
    logic              i_ready        = 1'b0;
    sbm_pkg::t_product o_product;

    product_scoreboard products = new();

    int cycle_count     = 0;
    bit rx_always_ready = 1'b0;
    int hold_requests   = 0;
    int holds_done      = 0;

    signed_booth_multiplier i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_product      (o_product)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic sbm_pkg::t_field pick_operand();
        int              r;
        sbm_pkg::t_field v;
        r = $urandom_range(0, 9);
        case (r)
            0: v = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
            1: v = sbm_pkg::t_field'($urandom_range(0, 16)) - 16'sd8;
            2: begin
                v = 16'(1) << $urandom_range(0, 15);
                if ($urandom_range(0, 1) != 0)
                    v = ~v;
            end
            default: v = sbm_pkg::t_field'($urandom());
        endcase
        return v;
    endfunction

    task automatic send_operands(input sbm_pkg::t_field mcand,
                                 input sbm_pkg::t_field mplier, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_multiplicand <= mcand;
        i_multiplier   <= mplier;
        do @(posedge i_clk); while (!o_ready);
        products.note_operands(mcand, mplier);
    endtask

    task automatic send_random(input int count, input bit no_gaps);
        repeat (count)
            send_operands(pick_operand(), pick_operand(), no_gaps ? 0 : sender_gap());
    endtask

    // receiver: checks each transfer, then picks the next ready level
    initial begin : receiver
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                products.check_product(o_product);
            if (hold_requests != holds_done) begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (rx_always_ready) begin
                i_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(5, 30);
                end
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes and booth bit patterns
        send_operands(16'sd0, 16'sd0, sender_gap());
        send_operands(16'sd1, 16'sd1, sender_gap());
        send_operands(-16'sd1, -16'sd1, sender_gap());
        send_operands(16'sd1, -16'sd1, sender_gap());
        send_operands(16'sh8000, 16'sh8000, sender_gap());
        send_operands(16'sh8000, 16'sh7fff, sender_gap());
        send_operands(16'sh7fff, 16'sh8000, sender_gap());
        send_operands(16'sh7fff, 16'sh7fff, sender_gap());
        send_operands(16'sh8000, 16'sd1, sender_gap());
        send_operands(16'sh8000, -16'sd1, sender_gap());
        send_operands(16'sd1, 16'sh8000, sender_gap());
        send_operands(-16'sd1, 16'sh8000, sender_gap());
        send_operands(16'sh7fff, -16'sd1, sender_gap());
        send_operands(16'sd0, 16'sh8000, sender_gap());
        send_operands(16'sh8000, 16'sd0, sender_gap());
        send_operands(16'sh5555, 16'sh5555, sender_gap());
        send_operands(16'shaaaa, 16'shaaaa, sender_gap());
        send_operands(16'sh5555, 16'shaaaa, sender_gap());
        send_operands(16'sd12345, -16'sd6789, sender_gap());
        send_operands(-16'sd1, 16'sh7fff, sender_gap());
        send_operands(16'sd7, 16'sh5555, sender_gap());
        send_operands(-16'sd300, 16'shaaaa, sender_gap());

        send_random(700, 1'b0);

        // back to back on both sides
        rx_always_ready = 1'b1;
        send_random(300, 1'b1);

        // long receiver hold while the sender keeps offering
        rx_always_ready = 1'b0;
        hold_requests++;
        send_random(80, 1'b1);

        send_random(520, 1'b0);
        i_valid <= 1'b0;

        rx_always_ready = 1'b1;
        while (products.expected_products.size() != 0)
            @(posedge i_clk);
        repeat (sbm_pkg::OPERAND_WIDTH + 8) @(posedge i_clk);

        if (products.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
